@@ rtl/tks_pkg.sv @@
`default_nettype none

package tks_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 64;

  localparam int COUNT_W = 7;
  localparam int INDEX_W = 6;
  localparam int WORD_W = 32;
  localparam int POS_W = 6;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_BINARY = 1'b1;

  localparam logic CFG_ENTRY_COUNT = 1'b0;
  localparam logic CFG_SEARCH_MODE = 1'b1;

  typedef struct packed {
    logic rot_left;
    logic rot_right;
    logic wr_en;
  } ring_op_t;

endpackage

`default_nettype wire

@@ rtl/tks_cell.sv @@
`default_nettype none

module tks_cell (
  input  wire logic                             clk,
  input  wire tks_pkg::ring_op_t                op,
  input  wire logic                             sel,
  input  wire logic signed [tks_pkg::WORD_W-1:0] wr_data,
  input  wire logic signed [tks_pkg::WORD_W-1:0] from_right,
  input  wire logic signed [tks_pkg::WORD_W-1:0] from_left,
  output logic signed [tks_pkg::WORD_W-1:0]      word
);

  always_ff @(posedge clk) begin
    priority if (op.wr_en && sel) begin
      word <= wr_data;
    end else if (op.rot_left) begin
      word <= from_right;
    end else if (op.rot_right) begin
      word <= from_left;
    end else begin
      word <= word;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tks_ring.sv @@
`default_nettype none

module tks_ring #(
  parameter int DEPTH = tks_pkg::TABLE_DEPTH_DEFAULT,
  parameter int IW = tks_pkg::INDEX_W
) (
  input  wire logic                              clk,
  input  wire tks_pkg::ring_op_t                 op,
  input  wire logic [IW-1:0]                     wr_slot,
  input  wire logic signed [tks_pkg::WORD_W-1:0] wr_data,
  output logic signed [tks_pkg::WORD_W-1:0]      head
);

  logic signed [tks_pkg::WORD_W-1:0] words [DEPTH];

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    localparam int RIGHT = (j + 1) % DEPTH;
    localparam int LEFT = (j + DEPTH - 1) % DEPTH;

    tks_cell u_cell (
      .clk        (clk),
      .op         (op),
      .sel        (wr_slot == IW'(j)),
      .wr_data    (wr_data),
      .from_right (words[RIGHT]),
      .from_left  (words[LEFT]),
      .word       (words[j])
    );
  end

  assign head = words[0];

endmodule

`default_nettype wire

@@ rtl/table_key_search.sv @@
// write: a write word lands at its accepting edge and input stays ready
// search: the ring turns one place per cycle toward each probe; with an empty table
//   the search ends at once and waits only for the output to be free
// one search at a time: the next word is taken the cycle after its result is loaded
// reset: clears configuration, handshake and ring alignment; table undefined until written
`default_nettype none

module table_key_search #(
  parameter int TABLE_DEPTH = tks_pkg::TABLE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [6:0]  cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // entry_index, entry_value, search_key, zero pad
  input  wire logic [0:0]  s_axis_tuser,  // func
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // position, zero pad
  output logic [0:0]       m_axis_tuser   // found
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = IW + 2;
  localparam int WW = IW + 7;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SEEK = 1'b1;

  logic [tks_pkg::COUNT_W-1:0]        entry_count;
  logic                               search_mode;
  logic                               state;
  logic                               state_next;
  logic signed [tks_pkg::WORD_W-1:0]  key;
  logic signed [CW-1:0]               lo;
  logic signed [CW-1:0]               lo_next;
  logic signed [CW-1:0]               hi;
  logic signed [CW-1:0]               hi_next;
  logic [IW-1:0]                      cur;
  logic [IW-1:0]                      cur_next;
  logic                               m_valid;
  logic                               out_found;
  logic [tks_pkg::POS_W-1:0]          out_pos;
  logic                               load_out;

  logic                               s_fire;
  logic                               s_func;
  logic [tks_pkg::INDEX_W-1:0]        s_idx;
  logic signed [tks_pkg::WORD_W-1:0]  s_val;
  logic signed [tks_pkg::WORD_W-1:0]  s_key;

  logic [WW-1:0]                      count_w;
  logic [WW-1:0]                      depth_w;
  logic [WW-1:0]                      n_w;
  logic signed [CW-1:0]               hi_init;
  logic [WW-1:0]                      idx_w;
  logic [WW-1:0]                      cur_w;
  logic [WW-1:0]                      slot_w;
  logic                               idx_ok;

  logic signed [CW-1:0]               span;
  logic signed [CW-1:0]               mid;
  logic signed [CW-1:0]               target;
  logic [IW-1:0]                      tgt_idx;
  logic [IW+tks_pkg::POS_W-1:0]       pos_w;
  logic                               active;
  logic                               at_tgt;
  logic                               hit;
  logic                               less;
  logic                               done;
  logic                               out_free;

  tks_pkg::ring_op_t                  op;
  logic signed [tks_pkg::WORD_W-1:0]  head;

  assign s_func = s_axis_tuser[0];
  assign s_idx = s_axis_tdata[5:0];
  assign s_val = s_axis_tdata[37:6];
  assign s_key = s_axis_tdata[69:38];

  assign s_axis_tready = (state == ST_IDLE);
  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;

  assign count_w = {{(WW-tks_pkg::COUNT_W){1'b0}}, entry_count};
  assign depth_w = WW'(TABLE_DEPTH);
  assign n_w = (count_w > depth_w) ? depth_w : count_w;
  assign hi_init = $signed(n_w[CW-1:0]) - CW'(1);

  // cell j holds logical entry (j + cur) mod depth
  assign idx_w = {{(WW-tks_pkg::INDEX_W){1'b0}}, s_idx};
  assign cur_w = {{(WW-IW){1'b0}}, cur};
  assign slot_w = (idx_w >= cur_w) ? (idx_w - cur_w) : (idx_w + depth_w - cur_w);
  assign idx_ok = (idx_w < depth_w);

  assign span = hi - lo;
  assign mid = lo + (span >>> 1);
  assign target = (search_mode == tks_pkg::MODE_BINARY) ? mid : lo;
  assign tgt_idx = target[IW-1:0];
  assign pos_w = {{tks_pkg::POS_W{1'b0}}, tgt_idx};
  assign active = (lo <= hi);
  assign at_tgt = (cur == tgt_idx);
  assign hit = at_tgt && (head == key);
  assign less = (head < key);
  assign done = !active || hit;
  assign out_free = !m_valid || m_axis_tready;

  always_comb begin
    op = '0;
    lo_next = lo;
    hi_next = hi;
    cur_next = cur;
    state_next = state;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_fire) begin
          if (s_func == tks_pkg::FUNC_SEARCH) begin
            lo_next = '0;
            hi_next = hi_init;
            state_next = ST_SEEK;
          end else if (idx_ok) begin
            op.wr_en = 1'b1;
          end
        end
      end
      ST_SEEK: begin
        if (done) begin
          if (out_free) begin
            load_out = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (at_tgt) begin
          if (search_mode == tks_pkg::MODE_BINARY) begin
            if (less) begin
              lo_next = target + CW'(1);
            end else begin
              hi_next = target - CW'(1);
            end
          end else begin
            lo_next = lo + CW'(1);
          end
        end else if (tgt_idx > cur) begin
          op.rot_left = 1'b1;
          cur_next = cur + IW'(1);
        end else begin
          op.rot_right = 1'b1;
          cur_next = cur - IW'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_valid <= 1'b0;
      cur <= '0;
      entry_count <= '0;
      search_mode <= tks_pkg::MODE_LINEAR;
    end else begin
      state <= state_next;
      cur <= cur_next;
      if (load_out) begin
        m_valid <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          tks_pkg::CFG_ENTRY_COUNT: entry_count <= cfg_data;
          tks_pkg::CFG_SEARCH_MODE: search_mode <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    lo <= lo_next;
    hi <= hi_next;
    if (s_fire && (s_func == tks_pkg::FUNC_SEARCH)) begin
      key <= s_key;
    end
    if (load_out) begin
      out_found <= active;
      out_pos <= active ? pos_w[tks_pkg::POS_W-1:0] : '0;
    end
  end

  tks_ring #(
    .DEPTH (TABLE_DEPTH),
    .IW    (IW)
  ) u_ring (
    .clk     (clk),
    .op      (op),
    .wr_slot (slot_w[IW-1:0]),
    .wr_data (s_val),
    .head    (head)
  );

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata = {2'b00, out_pos};
  assign m_axis_tuser = out_found;

`ifndef NO_ASSERTIONS
  a_no_write_while_turning: assert property (@(posedge clk) disable iff (rst)
    !(op.wr_en && (op.rot_left || op.rot_right)))
    else $error("ring written while turning");

  a_left_advances: assert property (@(posedge clk) disable iff (rst)
    op.rot_left |=> (cur == $past(cur) + IW'(1)))
    else $error("ring alignment lost on left turn");

  a_search_starts: assert property (@(posedge clk) disable iff (rst)
    (s_fire && (s_func == tks_pkg::FUNC_SEARCH)) |=> (state == ST_SEEK))
    else $error("search word did not start a search");

  a_cur_in_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, cur} < (IW+1)'(TABLE_DEPTH)))
    else $error("ring alignment beyond depth");
`endif

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = tks_pkg::TABLE_DEPTH_DEFAULT;
  localparam int SETTLE_CYCLES = 2 * DEPTH + 16;
  localparam int LONG_HOLD = 600;
  localparam int PHASES = 24;
  localparam int PHASE_WORDS = 40;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic        func;
    logic [5:0]  idx;
    logic [31:0] value;
    logic [31:0] key;
  } table_word_t;

  typedef struct packed {
    logic       found;
    logic [5:0] pos;
  } lookup_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = tks_pkg::CFG_ENTRY_COUNT;
  logic [6:0]  cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;  // entry_index, entry_value, search_key, zero pad
  logic [0:0]  s_axis_tuser = '0;  // func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;       // position, zero pad
  logic [0:0]  m_axis_tuser;       // found

  table_key_search #(.TABLE_DEPTH(DEPTH)) u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk = ~clk;

  // mirror of the block state
  logic signed [31:0] table_mirror [DEPTH];
  logic [6:0]         count_reg = '0;
  logic               mode_reg = tks_pkg::MODE_LINEAR;

  table_word_t pending_words_q [$];
  lookup_t     expected_hits_q [$];
  table_word_t cur_word;
  int          err_cnt = 0;
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  logic        hold_kick = 1'b0;
  logic        hold_seen;
  int          hold_left;

  function automatic lookup_t lookup_key(logic signed [31:0] key);
    lookup_t r;
    int n;
    int i;
    int lo;
    int hi;
    int mid;
    r = '0;
    n = (count_reg > DEPTH) ? DEPTH : int'(count_reg);
    if (mode_reg == tks_pkg::MODE_LINEAR) begin
      for (i = 0; i < n && !r.found; i++) begin
        if (table_mirror[i] == key) begin
          r.found = 1'b1;
          r.pos = i[5:0];
        end
      end
    end else begin
      lo = 0;
      hi = n - 1;
      while (!r.found && lo <= hi) begin
        mid = lo + (hi - lo) / 2;
        if (table_mirror[mid] == key) begin
          r.found = 1'b1;
          r.pos = mid[5:0];
        end else if (table_mirror[mid] < key) begin
          lo = mid + 1;
        end else begin
          hi = mid - 1;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    err_cnt++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (cur_word.func == tks_pkg::FUNC_WRITE) table_mirror[cur_word.idx] = cur_word.value;
        else expected_hits_q.push_back(lookup_key(cur_word.key));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_words_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          cur_word = pending_words_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {2'b00, cur_word.key, cur_word.value, cur_word.idx};
          s_axis_tuser <= cur_word.func;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_seen <= 1'b0;
      hold_left <= 0;
    end else if (hold_seen != hold_kick) begin
      hold_seen <= hold_kick;
      hold_left <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    lookup_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_hits_q.size() == 0) begin
        report_mismatch("result word with no search pending");
      end else begin
        e = expected_hits_q.pop_front();
        if (m_axis_tuser[0] !== e.found)
          report_mismatch($sformatf("found %b, expected %b", m_axis_tuser[0], e.found));
        if (m_axis_tdata[5:0] !== e.pos)
          report_mismatch($sformatf("position %0d, expected %0d", m_axis_tdata[5:0], e.pos));
      end
    end
  end

  task automatic set_pace(input int sel);
    @(negedge clk);
    case (sel)
      0: begin
        src_idle_pct = 0;
        sink_stall_pct = 0;
      end
      1: begin
        src_idle_pct = 75;
        sink_stall_pct = 0;
      end
      2: begin
        src_idle_pct = 0;
        sink_stall_pct = 75;
      end
      default: begin
        src_idle_pct = 25;
        sink_stall_pct = 25;
      end
    endcase
  endtask

  task automatic write_reg(input logic idx, input logic [6:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == tks_pkg::CFG_ENTRY_COUNT) count_reg = val;
    else mode_reg = val[0];
  endtask

  task automatic push_write(input logic [5:0] idx, input logic [31:0] value);
    table_word_t w;
    w.func = tks_pkg::FUNC_WRITE;
    w.idx = idx;
    w.value = value;
    w.key = $urandom;
    pending_words_q.push_back(w);
  endtask

  task automatic push_search(input logic [31:0] key);
    table_word_t w;
    w.func = tks_pkg::FUNC_SEARCH;
    w.idx = 6'($urandom);
    w.value = $urandom;
    w.key = key;
    pending_words_q.push_back(w);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words_q.size() != 0 || s_axis_tvalid || expected_hits_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_value();
    int v;
    case ($urandom_range(3))
      0: v = $urandom_range(6) - 3;
      1: begin
        case ($urandom_range(3))
          0: v = WORD_MIN;
          1: v = WORD_MAX;
          2: v = -1;
          default: v = 0;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic int pick_key();
    int n;
    int r;
    int k;
    n = (count_reg > DEPTH) ? DEPTH : int'(count_reg);
    r = $urandom_range(9);
    if (n > 0 && r < 6) begin
      k = table_mirror[$urandom_range(n - 1)];
      if (r == 5) k = k + ($urandom_range(1) ? 1 : -1);
    end else if (r < 8) begin
      k = pick_value();
    end else begin
      k = $urandom;
    end
    return k;
  endfunction

  // sorted ascending fill of the whole table
  task automatic fill_sorted(input bit narrow, input bit pin_ends);
    int vals [$];
    int i;
    for (i = 0; i < DEPTH; i++) vals.push_back(narrow ? $urandom_range(20) - 10 : $urandom);
    vals.sort();
    if (pin_ends) begin
      vals[0] = WORD_MIN;
      vals[DEPTH - 1] = WORD_MAX;
      vals[11] = vals[10];
    end
    for (i = 0; i < DEPTH; i++) push_write(i[5:0], vals[i]);
  endtask

  initial begin : stim
    int ph;
    int k;
    int cnt;
    logic mode;
    bit sorted;
    logic [31:0] dup_key;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty table, both modes
    set_pace(0);
    write_reg(tks_pkg::CFG_ENTRY_COUNT, 7'd0);
    write_reg(tks_pkg::CFG_SEARCH_MODE, 7'(tks_pkg::MODE_LINEAR));
    push_search(32'd0);
    push_search(WORD_MIN);
    wait_drained();
    write_reg(tks_pkg::CFG_SEARCH_MODE, 7'(tks_pkg::MODE_BINARY));
    push_search(WORD_MAX);
    wait_drained();

    fill_sorted(1'b0, 1'b1);
    wait_drained();
    dup_key = table_mirror[10];

    write_reg(tks_pkg::CFG_ENTRY_COUNT, 7'd64);
    write_reg(tks_pkg::CFG_SEARCH_MODE, 7'(tks_pkg::MODE_LINEAR));
    push_search(WORD_MIN);
    push_search(WORD_MAX);
    push_search(dup_key);
    push_search($urandom);
    wait_drained();
    write_reg(tks_pkg::CFG_SEARCH_MODE, 7'(tks_pkg::MODE_BINARY));
    push_search(WORD_MIN);
    push_search(WORD_MAX);
    push_search(dup_key);
    push_search($urandom);
    wait_drained();
    write_reg(tks_pkg::CFG_ENTRY_COUNT, 7'd1);
    push_search(WORD_MIN);
    push_search(WORD_MAX);
    wait_drained();
    write_reg(tks_pkg::CFG_ENTRY_COUNT, 7'd127);
    push_search(WORD_MAX);
    push_search(WORD_MIN);
    wait_drained();

    for (ph = 0; ph < PHASES; ph++) begin
      set_pace(ph % 4);
      mode = 1'($urandom_range(1));
      sorted = (mode == tks_pkg::MODE_BINARY) && ($urandom_range(3) != 0);
      case ($urandom_range(9))
        0: cnt = 0;
        1: cnt = $urandom_range(127, 65);
        2: cnt = DEPTH;
        3: cnt = 1;
        default: cnt = $urandom_range(DEPTH, 1);
      endcase
      write_reg(tks_pkg::CFG_ENTRY_COUNT, cnt[6:0]);
      write_reg(tks_pkg::CFG_SEARCH_MODE, 7'(mode));
      if (sorted) fill_sorted($urandom_range(3) == 0, 1'b0);
      if (ph == 5) begin
        @(negedge clk);
        src_idle_pct = 0;
        hold_kick = ~hold_kick;
      end
      for (k = 0; k < PHASE_WORDS; k++) begin
        if (!sorted && $urandom_range(9) < 3) push_write(6'($urandom), pick_value());
        else push_search(pick_key());
      end
      wait_drained();
    end

    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
